// ===== design/sha256_pkg.sv =====
// shared types, constants and the rotate function for the sha-256 engine
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWds  = 16;
  localparam int unsigned DgstWds = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic       absorb;      // take the accepted request's bytes
    logic       pad_first;   // start of padding: append 0x80
    logic       pad_zero;    // write one zero word
    logic       pad_len;     // write length word pair (two steps)
    logic       load;        // copy chain and block into working regs
    logic       round;       // run one round
    logic       fold;        // add working vars into chain
    logic       reinit;      // restore initial values
    logic [2:0] emit_idx;
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       block_full;
    logic [5:0] fill;
    logic       last_round;
  } sha_status_t;

  localparam logic [31:0] KTab [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HInit [DgstWds] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction

endpackage

// ===== design/sha256_ctrl.sv =====
// controller state machine for the sha-256 engine
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              byte_count_i,
  input  logic                    end_of_message_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output sha256_pkg::sha_cmd_t    cmd_o,
  input  sha256_pkg::sha_status_t stat_i
);
  import sha256_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        fin_q, fin_d;      // padding in progress
  logic [1:0]  pstep_q, pstep_d;  // 0 marker due, 1 zeros, 2 length hi, 3 length lo
  logic [2:0]  eidx_q, eidx_d;
  logic        acc;
  logic [2:0]  cnt_c;
  logic [6:0]  sum_c;
  logic        blk_done;          // accepted request completes the block

  assign acc      = in_valid_i && in_ready_o;
  assign cnt_c    = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
  assign sum_c    = {1'b0, stat_i.fill} + {4'd0, cnt_c};
  assign blk_done = sum_c[6];

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    pstep_d = pstep_q;
    eidx_d  = eidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (blk_done) begin
            state_d = ST_LOAD;
            fin_d   = end_of_message_i;
            pstep_d = 2'd0;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
            fin_d   = 1'b1;
            pstep_d = 2'd0;
          end
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (stat_i.last_round) state_d = ST_FOLD;
      ST_FOLD: begin
        if (!fin_q) state_d = ST_IDLE;
        else if (pstep_q == 2'd3) begin
          state_d = ST_EMIT;
          eidx_d  = 3'd0;
        end else state_d = ST_PAD;
      end
      ST_PAD: begin
        if (pstep_q == 2'd0) pstep_d = 2'd1;
        else if (pstep_q == 2'd1) begin
          if (stat_i.fill == 6'd56) pstep_d = 2'd2;
        end else if (pstep_q == 2'd2) pstep_d = 2'd3;
        if (stat_i.block_full) state_d = ST_LOAD;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          eidx_d = eidx_q + 3'd1;
          if (eidx_q == 3'd7) begin
            state_d = ST_IDLE;
            fin_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.emit_idx = eidx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.absorb = acc;
      end
      ST_LOAD:  cmd_o.load  = 1'b1;
      ST_ROUND: cmd_o.round = 1'b1;
      ST_FOLD:  cmd_o.fold  = 1'b1;
      ST_PAD: begin
        if (!stat_i.block_full) begin
          case (pstep_q)
            2'd0:    cmd_o.pad_first = 1'b1;
            2'd1:    cmd_o.pad_zero  = (stat_i.fill != 6'd56);
            default: cmd_o.pad_len   = 1'b1;
          endcase
        end
      end
      ST_EMIT: begin
        out_valid_o  = 1'b1;
        cmd_o.reinit = out_ready_i && (eidx_q == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
      pstep_q <= 2'd0;
      eidx_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      pstep_q <= pstep_d;
      eidx_q  <= eidx_d;
    end
  end

endmodule

// ===== design/sha256_dpath.sv =====
// block buffer, message schedule and round datapath for the sha-256 engine
`timescale 1ns / 1ps
module sha256_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [31:0]             data_word_i,
  input  logic [2:0]              byte_count_i,
  input  sha256_pkg::sha_cmd_t    cmd_i,
  output sha256_pkg::sha_status_t stat_o,
  output logic [31:0]             digest_word_o
);
  import sha256_pkg::*;

  logic [31:0] blk_q [BlkWds];
  logic [31:0] w_q   [BlkWds];
  logic [31:0] v_q   [8];
  logic [31:0] h_q   [DgstWds];
  logic [5:0]  fill_q;
  logic        full_q;       // 64 bytes held, compression pending
  logic [63:0] mlen_q;
  logic [5:0]  rnd_q;
  logic        pad_hi_q;     // next length word is the high half
  logic [31:0] spill_q;      // bytes past the end of a full block
  logic        spill_pend_q; // spill_q goes to word 0 once the block is loaded

  logic [2:0]  cnt;
  logic [6:0]  newfill;
  logic [31:0] wcur, wnext, s0w, s1w, t1, t2, bs0, bs1, ch, maj;
  logic [63:0] bits;

  assign cnt  = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
  assign bits = {mlen_q[60:0], 3'b000};

  // schedule word for this round: window shifts left each round
  assign s0w   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1w   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnext = w_q[0] + s0w + w_q[9] + s1w;
  assign wcur  = w_q[0];

  assign bs0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign bs1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1  = v_q[7] + bs1 + ch + KTab[rnd_q] + wcur;
  assign t2  = bs0 + maj;

  assign stat_o.block_full = full_q;
  assign stat_o.fill       = fill_q;
  assign stat_o.last_round = (rnd_q == 6'd63);
  assign digest_word_o     = h_q[cmd_i.emit_idx];

  // byte merge for absorb: whole or partial word at a byte offset
  logic [3:0]  wi;
  logic [1:0]  bo;
  logic [31:0] merged, cur;
  logic [2:0]  room, take, rest;
  logic [31:0] spill;

  always_comb begin
    wi     = fill_q[5:2];
    bo     = fill_q[1:0];
    cur    = (bo == 2'd0) ? 32'd0 : blk_q[wi];
    room   = 3'd4 - {1'b0, bo};
    take   = (cnt < room) ? cnt : room;
    rest   = cnt - take;
    merged = cur;
    spill  = 32'd0;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(take)) merged[31-8*(int'(bo)+i) -: 8] = data_word_i[31-8*i -: 8];
      if (i < int'(rest)) spill[31-8*i -: 8] = data_word_i[31-8*(int'(take)+i) -: 8];
    end
    newfill = {1'b0, fill_q} + {4'd0, cnt};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb && cnt != 3'd0) begin
      blk_q[wi] <= merged;
      if (rest != 3'd0 && wi != 4'd15) blk_q[wi + 4'd1] <= spill;
    end
    if (cmd_i.absorb) spill_q <= spill;
    if (cmd_i.pad_first) begin
      blk_q[wi] <= (bo == 2'd0) ? 32'h8000_0000 : (blk_q[wi] | (32'h80 << (8 * (3 - bo))));
    end
    if (cmd_i.pad_zero) blk_q[wi] <= 32'd0;
    if (cmd_i.pad_len) blk_q[wi] <= pad_hi_q ? bits[63:32] : bits[31:0];
    if (cmd_i.load) begin
      for (int i = 0; i < BlkWds; i++) w_q[i] <= blk_q[i];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      if (spill_pend_q) blk_q[0] <= spill_q;
    end
    if (cmd_i.round) begin
      for (int i = 0; i < BlkWds - 1; i++) w_q[i] <= w_q[i+1];
      w_q[BlkWds-1] <= wnext;
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DgstWds; i++) h_q[i] <= HInit[i];
      fill_q       <= '0;
      full_q       <= 1'b0;
      mlen_q       <= '0;
      rnd_q        <= '0;
      pad_hi_q     <= 1'b1;
      spill_pend_q <= 1'b0;
    end else begin
      if (cmd_i.absorb) begin
        mlen_q       <= mlen_q + {61'd0, cnt};
        fill_q       <= newfill[5:0];
        full_q       <= newfill[6];
        spill_pend_q <= (rest != 3'd0) && (wi == 4'd15);
      end
      // marker word and zero words both leave the fill on a word boundary
      if (cmd_i.pad_first || cmd_i.pad_zero) begin
        fill_q <= {fill_q[5:2] + 4'd1, 2'b00};
        full_q <= (fill_q[5:2] == 4'd15);
      end
      if (cmd_i.pad_len) begin
        pad_hi_q <= !pad_hi_q;
        fill_q   <= fill_q + 6'd4;
        full_q   <= !pad_hi_q;
      end
      if (cmd_i.load) begin
        rnd_q        <= '0;
        spill_pend_q <= 1'b0;
      end
      if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.fold) begin
        for (int i = 0; i < DgstWds; i++) h_q[i] <= h_q[i] + v_q[i];
        full_q <= 1'b0;
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < DgstWds; i++) h_q[i] <= HInit[i];
        fill_q   <= '0;
        mlen_q   <= '0;
        pad_hi_q <= 1'b1;
      end
    end
  end

endmodule

// ===== design/sha256_hash_engine_core.sv =====
// top level of the streaming sha-256 engine
`timescale 1ns / 1ps
// streaming sha-256: each request carries up to four big-endian message bytes
// (counts above four act as four) and an end mark. a request that neither
// completes a block nor carries the end mark leaves input ready high; one that
// completes a 64-byte block holds input ready low through the load, 64 rounds
// through the single shared round unit and the fold into the chaining words. on
// the end mark the engine pads a word a cycle, pausing before the two length
// words and after each full padding block, compresses one or two more
// blocks, then presents the eight digest words, h0 first, one per accepted
// output request, and returns to the initial values for the next message
module sha256_hash_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha256_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t stat;

  // sequencing: absorb, padding, rounds and digest readout
  sha256_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .byte_count_i,
    .end_of_message_i,
    .out_valid_o,
    .out_ready_i,
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // block buffer, schedule window, working variables and chaining words
  sha256_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .data_word_i,
    .byte_count_i,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .digest_word_o
  );

  assign word_index_o = cmd.emit_idx;
  assign last_word_o  = (cmd.emit_idx == 3'd7);

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the streaming sha-256 engine
`timescale 1ns / 1ps
module testbench;

  // clock, reset and the two channels
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] data_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sha256_hash_engine_core dut (.*);

  // one digest word as the engine should present it
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  // directed request; known_h0 marks rows whose first digest word is typed in
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        eom;
    logic        known_h0;
    logic [31:0] h0;
  } stim_row_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // predictor state: chaining words, partly filled block, fill level, length
  logic [31:0]  chain_h [8];
  logic [31:0]  blk_buf [16];
  int unsigned  blk_fill;
  logic [63:0]  msg_len;
  digest_beat_t digest_q [$];

  bit fail_seen = 1'b0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_req = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] v, int unsigned s);
    logic [63:0] dbl;
    dbl = {v, v} >> s;
    return dbl[31:0];
  endfunction

  // full 64-round compression of blk_buf into chain_h
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    {va, vb, vc, vd} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3]};
    {ve, vf, vg, vh} = {chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
         + ((ve & vf) ^ (~ve & vg)) + RoundK[r] + w[r];
      t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
         + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    chain_h[0] += va; chain_h[1] += vb; chain_h[2] += vc; chain_h[3] += vd;
    chain_h[4] += ve; chain_h[5] += vf; chain_h[6] += vg; chain_h[7] += vh;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    int unsigned slot;
    slot = blk_fill >> 2;
    if (blk_fill[1:0] == 2'd0) blk_buf[slot] = '0;
    blk_buf[slot] |= 32'(b) << (8 * (3 - blk_fill[1:0]));
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain_h[i] = StartH[i];
    blk_fill = 0;
    msg_len = '0;
  endfunction

  // apply one accepted request; on the end mark queue the eight digest words
  function automatic void hash_request(logic [31:0] d, logic [2:0] c, logic e);
    int unsigned n;
    logic [63:0] bit_len;
    n = (c > 3'd4) ? 4 : c;
    for (int i = 0; i < n; i++) absorb_byte(d[31-8*i -: 8]);
    msg_len += n;
    if (e) begin
      bit_len = msg_len << 3;
      absorb_byte(8'h80);
      while (blk_fill != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) digest_q.push_back({chain_h[i], 3'(i), i == 7});
      restart_message();
    end
  endfunction

  // offer one request from the falling edge, hold it until taken
  task automatic send_request(logic [31:0] d, logic [2:0] c, logic e);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_word_i      <= d;
    byte_count_i     <= c;
    end_of_message_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    hash_request(d, c, e);
    // valid stays up; the next request or go_quiet changes it at a falling edge
    fork
      begin
        @(negedge clk_i);
      end
    join_none
  endtask

  // valid is lowered only between bursts, so no double assignment in a step
  task automatic go_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // random message of one to 31 requests: mostly full words, with odd counts
  task automatic send_message(inout int sent);
    int n;
    logic [2:0] c;
    n = ($urandom_range(3) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 30);
    for (int i = 0; i <= n; i++) begin
      c = ($urandom_range(9) < 7) ? 3'd4 : 3'($urandom_range(7));
      send_request($urandom, c, i == n);
      sent++;
    end
  endtask

  // receiver: random stalls plus a long hold-off counted here
  always @(negedge clk_i) begin
    static int hold_cnt = 0;
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // compare every accepted digest word with the oldest expectation
  always @(posedge clk_i) begin
    digest_beat_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $error("digest word 0x%08h arrived with nothing expected", digest_word_o);
        fail_seen = 1'b1;
      end else begin
        exp_b = digest_q.pop_front();
        if (digest_word_o !== exp_b.word) begin
          $error("digest_word expected 0x%08h actual 0x%08h", exp_b.word, digest_word_o);
          fail_seen = 1'b1;
        end
        if (word_index_o !== exp_b.idx) begin
          $error("word_index expected %0d actual %0d", exp_b.idx, word_index_o);
          fail_seen = 1'b1;
        end
        if (last_word_o !== exp_b.last) begin
          $error("last_word expected %0d actual %0d", exp_b.last, last_word_o);
          fail_seen = 1'b1;
        end
      end
    end
  end

  stim_row_t dir_rows [12];

  initial begin
    int sent;
    int mark;
    // empty message and "abc" digests, unused bytes ignored, oversize counts,
    // empty requests with and without end mark
    dir_rows = '{
      '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'he3b0c442},
      '{32'h61626300, 3'd3, 1'b1, 1'b1, 32'hba7816bf},
      '{32'h616263ff, 3'd3, 1'b1, 1'b1, 32'hba7816bf},
      '{32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
      '{32'hffffffff, 3'd7, 1'b0, 1'b0, 32'h0},
      '{32'h00000000, 3'd6, 1'b0, 1'b0, 32'h0},
      '{32'ha5a5a5a5, 3'd5, 1'b0, 1'b0, 32'h0},
      '{32'h12345678, 3'd4, 1'b0, 1'b0, 32'h0},
      '{32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
      '{32'hdeadbeef, 3'd1, 1'b1, 1'b0, 32'h0},
      '{32'hcafef00d, 3'd2, 1'b0, 1'b0, 32'h0},
      '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0}
    };
    restart_message();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, no idling
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].data, dir_rows[i].cnt, dir_rows[i].eom);
      if (dir_rows[i].known_h0) begin
        // the eight words of this message were queued last
        mark = digest_q.size() - 8;
        digest_q[mark].word = dir_rows[i].h0;
      end
    end
    sent = 0;

    // random part in three idling phases; long receiver hold in the last
    src_idle_pct = 8;  snk_idle_pct = 63;
    while (sent < 110) send_message(sent);
    src_idle_pct = 63; snk_idle_pct = 8;
    while (sent < 220) send_message(sent);
    src_idle_pct = 0;  snk_idle_pct = 0;
    hold_req = 1'b1;
    while (sent < 340) send_message(sent);
    go_quiet();

    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!fail_seen && digest_q.size() == 0) begin
      $display("PASS sha256_hash_engine_core");
    end else begin
      $display("FAIL sha256_hash_engine_core");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL sha256_hash_engine_core");
    $finish;
  end

endmodule
